// ----- rtl/spwm_pkg.sv -----
// Shared types and constants for the SPWM duty generator with a Taylor sine.
// No dependencies; every other file refers to this package by scoped names.
package spwm_pkg;

  // Default values of the tunable fixed-point formats.
  localparam int PHASE_BITS_DEF     = 24;
  localparam int SINE_FRAC_BITS_DEF = 16;

  // Field and register widths.
  localparam int TIME_W     = 32;
  localparam int FREQ_W     = 18;
  localparam int AMP_W      = 15;
  localparam int DUTY_W     = 14;
  localparam int AMPK_W     = 29;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 18;

  // The frequency-time product carries 28 fractional bits of a turn.
  localparam int PROD_FRAC = 28;

  // Two pi in units of 2^-29.
  localparam int          TWO_PI_W   = 32;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  localparam logic [DUTY_W-1:0] FULL_SCALE = 14'd10000;

  // Register reset values.
  localparam logic [FREQ_W-1:0] FREQ_RESET = 18'd12800;
  localparam logic [AMPK_W-1:0] AMPK_RESET = 29'd131070000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FREQ = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_AMP  = 8'd1;

  // Register contents as seen by the datapath. The amplitude is held
  // already multiplied by the full-scale count.
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [AMPK_W-1:0] amp_k;
  } cfg_t;

endpackage

// ----- rtl/spwm_cfg_regs.sv -----
// Configuration registers of the SPWM duty generator.
// Depends on spwm_pkg for widths, register indexes and reset values.
module spwm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spwm_pkg::CFG_DATA_W-1:0] cfg_data,
  output spwm_pkg::cfg_t                  cfg
);

  spwm_pkg::cfg_t cfg_r;
  spwm_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        spwm_pkg::CFG_IDX_FREQ: cfg_nxt.freq = cfg_data[spwm_pkg::FREQ_W-1:0];
        spwm_pkg::CFG_IDX_AMP: begin
          cfg_nxt.amp_k = spwm_pkg::AMPK_W'(cfg_data[spwm_pkg::AMP_W-1:0])
                        * spwm_pkg::AMPK_W'(spwm_pkg::FULL_SCALE);
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.freq  <= spwm_pkg::FREQ_RESET;
      cfg_r.amp_k <= spwm_pkg::AMPK_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/spwm_phase.sv -----
// Phase front end: frequency times time, quadrant fold, and scaling to radians.
// Four register stages. Depends on spwm_pkg.
module spwm_phase #(
  parameter int PHASE_BITS     = spwm_pkg::PHASE_BITS_DEF,
  parameter int SINE_FRAC_BITS = spwm_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [spwm_pkg::TIME_W-1:0]   sample_time,
  input  logic [spwm_pkg::FREQ_W-1:0]   freq,
  output logic                          x_valid,
  output logic [SINE_FRAC_BITS:0]       x,
  output logic                          x_neg
);

  localparam int PF     = spwm_pkg::PROD_FRAC;
  localparam int PROD_W = PF + spwm_pkg::FREQ_W;
  localparam int H_W    = PHASE_BITS - 1;
  localparam int XP_W   = H_W + spwm_pkg::TWO_PI_W;
  localparam int SH     = PHASE_BITS + 29 - SINE_FRAC_BITS;
  localparam int X_W    = SINE_FRAC_BITS + 1;

  localparam logic [PHASE_BITS-1:0] HALF    = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [H_W-1:0]        QUARTER = {1'b1, {(PHASE_BITS-2){1'b0}}};
  localparam logic [XP_W:0]         XP_RND  = {{XP_W{1'b0}}, 1'b1} << (SH-1);

  logic [3:0] valid_r;

  logic [PROD_W-1:0]     prod;
  logic [PF-1:0]         frac_r;
  logic [PHASE_BITS-1:0] phase;
  logic [H_W-1:0]        h_low;
  logic [H_W-1:0]        h_nxt;
  logic [H_W-1:0]        h_r;
  logic [XP_W-1:0]       xp_r;
  logic [XP_W:0]         xp_sum;
  logic [X_W-1:0]        x_r;
  logic [2:0]            neg_r;

  // Only the fractional turns matter, so only the low time bits enter.
  assign prod = PROD_W'(freq) * PROD_W'(sample_time[PF-1:0]);

  generate
    if (PHASE_BITS <= PF) begin : g_trunc
      assign phase = frac_r[PF-1 -: PHASE_BITS];
    end else begin : g_pad
      assign phase = {frac_r, {(PHASE_BITS-PF){1'b0}}};
    end
  endgenerate

  // Mirror the second quarter of each half back onto the first.
  assign h_low = phase[PHASE_BITS-2:0];
  assign h_nxt = (h_low > QUARTER) ? H_W'(HALF - {1'b0, h_low}) : h_low;

  assign xp_sum = {1'b0, xp_r} + XP_RND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    frac_r   <= prod[PF-1:0];
    h_r      <= h_nxt;
    neg_r[0] <= phase[PHASE_BITS-1];
    xp_r     <= XP_W'(h_r) * XP_W'(spwm_pkg::TWO_PI_Q29);
    neg_r[1] <= neg_r[0];
    x_r      <= xp_sum[SH +: X_W];
    neg_r[2] <= neg_r[1];
  end

  assign x_valid = valid_r[3];
  assign x       = x_r;
  assign x_neg   = neg_r[2];

endmodule

// ----- rtl/spwm_taylor.sv -----
// Fifth-order Taylor sine x - x^3/6 + x^5/120 in unsigned fixed point.
// Nine register stages; divisions use reciprocal multiplies. Depends on spwm_pkg.
module spwm_taylor #(
  parameter int SINE_FRAC_BITS = spwm_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    x_valid,
  input  logic [SINE_FRAC_BITS:0] x,
  input  logic                    x_neg,
  output logic                    p_valid,
  output logic [SINE_FRAC_BITS:0] p,
  output logic                    p_neg
);

  localparam int SF    = SINE_FRAC_BITS;
  localparam int X_W   = SF + 1;
  localparam int XX_W  = 2 * SF + 2;
  localparam int X2_W  = SF + 2;
  localparam int X2X_W = X2_W + X_W;
  localparam int X3_W  = SF + 2;
  localparam int X5P_W = X3_W + X2_W;
  localparam int X5_W  = SF + 4;

  // Division by 6 is a halving and then an exact reciprocal multiply by 1/3.
  localparam int D3_W = X3_W - 1;
  localparam int K3   = D3_W + 2;
  localparam int M3_W = D3_W + 1;
  localparam int Q3_W = D3_W + M3_W;
  localparam int T3_W = Q3_W - K3;
  localparam logic [M3_W-1:0] M3 = M3_W'(((64'd1 << K3) + 64'd2) / 64'd3);

  // Division by 120 is a shift by three and then an exact multiply by 1/15.
  localparam int D5_W = X5_W - 3;
  localparam int K5   = D5_W + 4;
  localparam int M5_W = D5_W + 1;
  localparam int Q5_W = D5_W + M5_W;
  localparam int T5_W = Q5_W - K5;
  localparam logic [M5_W-1:0] M5 = M5_W'(((64'd1 << K5) + 64'd14) / 64'd15);

  localparam logic [XX_W:0]  XX_RND  = {{XX_W{1'b0}}, 1'b1} << (SF-1);
  localparam logic [X2X_W:0] X2X_RND = {{X2X_W{1'b0}}, 1'b1} << (SF-1);
  localparam logic [X5P_W:0] X5P_RND = {{X5P_W{1'b0}}, 1'b1} << (SF-1);

  logic [8:0] valid_r;
  logic [8:0] neg_r;
  logic [X_W-1:0] x_d_r [7];

  logic [XX_W-1:0]  xx_r;
  logic [XX_W:0]    xx_sum;
  logic [X2_W-1:0]  x2_r;
  logic [X2_W-1:0]  x2_d_r;
  logic [X2_W-1:0]  x2_d2_r;
  logic [X2X_W-1:0] x2x_r;
  logic [X2X_W:0]   x2x_sum;
  logic [X3_W-1:0]  x3_r;
  logic [X5P_W-1:0] x5p_r;
  logic [X5P_W:0]   x5p_sum;
  logic [X3_W-1:0]  v3_r;
  logic [X5_W-1:0]  x5_r;
  logic [Q3_W-1:0]  q3p_r;
  logic [T3_W-1:0]  t3_r;
  logic [X5_W-1:0]  v5_r;
  logic [Q5_W-1:0]  q5p_r;
  logic [X_W-1:0]   a_r;
  logic [X_W-1:0]   p_r;

  assign xx_sum  = {1'b0, xx_r} + XX_RND;
  assign x2x_sum = {1'b0, x2x_r} + X2X_RND;
  assign x5p_sum = {1'b0, x5p_r} + X5P_RND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[7:0], x_valid};
    end
  end

  always_ff @(posedge clk) begin
    neg_r    <= {neg_r[7:0], x_neg};
    x_d_r[0] <= x;
    for (int i = 1; i < 7; i++) begin
      x_d_r[i] <= x_d_r[i-1];
    end
    xx_r    <= XX_W'(x) * XX_W'(x);
    x2_r    <= xx_sum[SF +: X2_W];
    x2x_r   <= X2X_W'(x2_r) * X2X_W'(x_d_r[1]);
    x2_d_r  <= x2_r;
    x2_d2_r <= x2_d_r;
    x3_r    <= x2x_sum[SF +: X3_W];
    x5p_r   <= X5P_W'(x3_r) * X5P_W'(x2_d2_r);
    v3_r    <= x3_r + X3_W'(3);
    x5_r    <= x5p_sum[SF +: X5_W];
    q3p_r   <= Q3_W'(v3_r[X3_W-1:1]) * Q3_W'(M3);
    t3_r    <= q3p_r[K3 +: T3_W];
    v5_r    <= x5_r + X5_W'(60);
    q5p_r   <= Q5_W'(v5_r[X5_W-1:3]) * Q5_W'(M5);
    a_r     <= x_d_r[6] - X_W'(t3_r);
    p_r     <= a_r + X_W'(q5p_r[K5 +: T5_W]);
  end

  assign p_valid = valid_r[8];
  assign p       = p_r;
  assign p_neg   = neg_r[8];

endmodule

// ----- rtl/spwm_scale.sv -----
// Output scaling: offset the sine to 0..2, apply amplitude times full scale,
// round half up and clamp. Three register stages. Depends on spwm_pkg.
module spwm_scale #(
  parameter int SINE_FRAC_BITS = spwm_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          p_valid,
  input  logic [SINE_FRAC_BITS:0]       p,
  input  logic                          p_neg,
  input  logic [spwm_pkg::AMPK_W-1:0]   amp_k,
  output logic                          out_valid,
  output logic [spwm_pkg::DUTY_W-1:0]   out_duty_value
);

  localparam int SF    = SINE_FRAC_BITS;
  localparam int DW    = spwm_pkg::DUTY_W;
  localparam int N_W   = SF + 2;
  localparam int NUM_W = N_W + spwm_pkg::AMPK_W;

  localparam logic [N_W-1:0]   ONE   = {2'b01, {SF{1'b0}}};
  localparam logic [NUM_W-1:0] LIMIT = NUM_W'(spwm_pkg::FULL_SCALE) << (SF + 15);
  localparam logic [NUM_W:0]   RND   = {{NUM_W{1'b0}}, 1'b1} << (SF + 14);

  logic [2:0]       valid_r;
  logic [N_W-1:0]   n_r;
  logic [1:0]       zero_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W:0]   num_sum;
  logic [DW-1:0]    duty_nxt;
  logic [DW-1:0]    duty_r;

  assign num_sum = {1'b0, num_r} + RND;

  always_comb begin
    if (zero_r[1]) begin
      duty_nxt = '0;
    end else if (num_r > LIMIT) begin
      duty_nxt = spwm_pkg::FULL_SCALE;
    end else begin
      duty_nxt = num_sum[SF+15 +: DW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[1:0], p_valid};
    end
  end

  always_ff @(posedge clk) begin
    // A negative half with the polynomial just above one is pinned to zero.
    zero_r[0] <= p_neg && ({1'b0, p} > ONE);
    n_r       <= p_neg ? (ONE - N_W'(p)) : (ONE + N_W'(p));
    zero_r[1] <= zero_r[0];
    num_r     <= NUM_W'(n_r) * NUM_W'(amp_k);
    duty_r    <= duty_nxt;
  end

  assign out_valid      = valid_r[2];
  assign out_duty_value = duty_r;

endmodule

// ----- rtl/spwm_duty_from_taylor_sine.sv -----
// SPWM duty generator top level: config registers, phase, Taylor sine, scaling.
// Depends on spwm_pkg, spwm_cfg_regs, spwm_phase, spwm_taylor and spwm_scale.
// Pipeline depth: 16 register stages from the accepting edge to out_valid.
// Throughput: one request per clock cycle, set by the fully pipelined multipliers.
// Reset (synchronous, rst_n low) empties the pipeline and loads register defaults;
// busy is high during reset and in the first cycle after it. The receiver cannot stall.
module spwm_duty_from_taylor_sine #(
  parameter int PHASE_BITS     = spwm_pkg::PHASE_BITS_DEF,
  parameter int SINE_FRAC_BITS = spwm_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel: a request is taken when start is high and busy is low.
  input  logic                            start,
  output logic                            busy,
  input  logic [spwm_pkg::TIME_W-1:0]     in_sample_time,
  // Result channel: one result per request, marked by out_valid for one cycle.
  output logic                            out_valid,
  output logic [spwm_pkg::DUTY_W-1:0]     out_duty_value,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spwm_pkg::CFG_DATA_W-1:0] cfg_data
);

  spwm_pkg::cfg_t cfg;

  logic                    busy_r;
  logic                    in_accept;
  logic                    x_valid;
  logic [SINE_FRAC_BITS:0] x;
  logic                    x_neg;
  logic                    p_valid;
  logic [SINE_FRAC_BITS:0] p;
  logic                    p_neg;

  // The pipeline never stalls, so requests are refused only during reset and in
  // the cycle right after it, while the register defaults settle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign in_accept = start && !busy_r;

  // Registers are held as the frequency and the amplitude already multiplied
  // by the full-scale count, so no per-request work is spent on that product.
  spwm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stages 1 to 4: the phase in turns is the low fraction of frequency times
  // time, folded into the first quadrant with the half kept as a sign, and then
  // turned into an angle in radians with SINE_FRAC_BITS fractional bits.
  spwm_phase #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_accept),
    .sample_time (in_sample_time),
    .freq        (cfg.freq),
    .x_valid     (x_valid),
    .x           (x),
    .x_neg       (x_neg)
  );

  // Stages 5 to 13: powers of the angle are each rounded to the working
  // precision, and the two series terms are divided by constant reciprocals.
  spwm_taylor #(
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_taylor (
    .clk     (clk),
    .rst_n   (rst_n),
    .x_valid (x_valid),
    .x       (x),
    .x_neg   (x_neg),
    .p_valid (p_valid),
    .p       (p),
    .p_neg   (p_neg)
  );

  // Stages 14 to 16: the signed sine is offset to 0..2, scaled by amplitude
  // and full scale, rounded half up and clamped to the full-scale count.
  spwm_scale #(
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .p_valid        (p_valid),
    .p              (p),
    .p_neg          (p_neg),
    .amp_k          (cfg.amp_k),
    .out_valid      (out_valid),
    .out_duty_value (out_duty_value)
  );

endmodule

// ----- verif/spwm_duty_from_taylor_sine_tb.sv -----
// Self-checking testbench for the SPWM duty generator with a Taylor sine.
// It needs spwm_pkg and the spwm_duty_from_taylor_sine RTL; it predicts
// every duty value in a small scoreboard class.
`timescale 1ns / 1ps

class duty_scoreboard;
  logic [spwm_pkg::FREQ_W-1:0] freq;
  logic [spwm_pkg::AMP_W-1:0]  amp;
  logic [spwm_pkg::DUTY_W-1:0] expected_duty[$];
  int                          fail_count;

  function new();
    freq       = spwm_pkg::FREQ_RESET;
    amp        = 15'd13107;
    fail_count = 0;
  endfunction

  // The register file masks data to each register's width and drops
  // writes to any index it does not decode.
  function void write_reg(logic [spwm_pkg::CFG_IDX_W-1:0] idx,
                          logic [spwm_pkg::CFG_DATA_W-1:0] data);
    if (idx == spwm_pkg::CFG_IDX_FREQ) begin
      freq = data[spwm_pkg::FREQ_W-1:0];
    end else if (idx == spwm_pkg::CFG_IDX_AMP) begin
      amp = data[spwm_pkg::AMP_W-1:0];
    end
  endfunction

  // Right shift with rounding half up.
  function bit [63:0] round_shift(bit [63:0] v, int sh);
    if (sh == 0) begin
      return v;
    end
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function logic [spwm_pkg::DUTY_W-1:0] predict_duty(logic [spwm_pkg::TIME_W-1:0] t);
    bit [63:0]     phase, half_turn, quarter_turn, h, x, x2, x3, x5, p, num, cap, duty;
    bit            neg;
    longint signed n;
    int            pb, fb;
    pb = spwm_pkg::PHASE_BITS_DEF;
    fb = spwm_pkg::SINE_FRAC_BITS_DEF;
    // Phase in units of 2^-28 turn, then brought to PHASE_BITS.
    phase = (64'(freq) * 64'(t)) & ((64'd1 << spwm_pkg::PROD_FRAC) - 64'd1);
    if (pb <= spwm_pkg::PROD_FRAC) begin
      phase = phase >> (spwm_pkg::PROD_FRAC - pb);
    end else begin
      phase = phase << (pb - spwm_pkg::PROD_FRAC);
    end
    half_turn    = 64'd1 << (pb - 1);
    quarter_turn = 64'd1 << (pb - 2);
    neg = (phase & half_turn) != 64'd0;
    h   = phase & (half_turn - 64'd1);
    if (h > quarter_turn) begin
      h = half_turn - h;
    end
    // Angle in radians, then the fifth-order polynomial.
    x  = round_shift(h * 64'(spwm_pkg::TWO_PI_Q29), pb + 29 - fb);
    x2 = round_shift(x * x, fb);
    x3 = round_shift(x2 * x, fb);
    x5 = round_shift(x3 * x2, fb);
    p  = x - (x3 + 64'd3) / 64'd6 + (x5 + 64'd60) / 64'd120;
    if (neg) begin
      n = longint'(64'd1 << fb) - longint'(p);
    end else begin
      n = longint'(64'd1 << fb) + longint'(p);
    end
    if (n < 0) begin
      return '0;
    end
    num = 64'(n) * 64'(amp) * 64'(spwm_pkg::FULL_SCALE);
    cap = 64'(spwm_pkg::FULL_SCALE) << (fb + 15);
    if (num > cap) begin
      return spwm_pkg::FULL_SCALE;
    end
    duty = (num + (64'd1 << (fb + 14))) >> (fb + 15);
    return duty[spwm_pkg::DUTY_W-1:0];
  endfunction

  function void note_request(logic [spwm_pkg::TIME_W-1:0] t);
    expected_duty.push_back(predict_duty(t));
  endfunction

  function void check_result(logic [spwm_pkg::DUTY_W-1:0] got);
    logic [spwm_pkg::DUTY_W-1:0] want;
    if (expected_duty.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("ERROR: duty_value %0d arrived with no request outstanding", got);
      end
      return;
    end
    want = expected_duty.pop_front();
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("ERROR: duty_value expected %0d, got %0d", want, got);
      end
    end
  endfunction
endclass

module spwm_duty_from_taylor_sine_tb;

  // Cycles with no handshake of any kind before the run is declared hung.
  // The longest legal quiet stretch is a sender gap plus the pipeline depth.
  localparam int WATCHDOG_LIMIT = 2000;
  // The pipeline is 16 deep; wait a little longer for stray results.
  localparam int DRAIN_CYCLES   = 24;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_REQUESTS = 300;

  localparam logic [spwm_pkg::AMP_W-1:0] AMP_UNITY = 15'd16384;
  localparam logic [spwm_pkg::AMP_W-1:0] AMP_MAX   = 15'd32767;
  localparam logic [spwm_pkg::FREQ_W-1:0] FREQ_MAX = 18'd262143;
  // Indexes that no register answers to.
  localparam logic [spwm_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 8'd2;
  localparam logic [spwm_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 8'd255;

  // With a frequency of one count, one quarter turn is 2^26 time units.
  localparam logic [31:0] QUARTER_T = 32'h0400_0000;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [spwm_pkg::TIME_W-1:0]       in_sample_time = '0;
  logic                              out_valid;
  logic [spwm_pkg::DUTY_W-1:0]       out_duty_value;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [spwm_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [spwm_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  duty_scoreboard sb;
  int             quiet_cycles = 0;

  spwm_duty_from_taylor_sine uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_sample_time (in_sample_time),
    .out_valid      (out_valid),
    .out_duty_value (out_duty_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Results are sampled at the edge that ends their cycle. Every driven
  // signal changes by nonblocking assignment at the edge, so the values read
  // here are the ones the design saw before the edge.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      sb.check_result(out_duty_value);
    end
  end

  // Watchdog: any accepted request, result or register write counts as
  // progress. A long quiet stretch means the design has hung.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || out_valid === 1'b1 ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Present one request and hold it until the design takes it. The start
  // line stays high on return so that back-to-back requests need no toggle;
  // the caller lowers it before a gap.
  task automatic send_request(logic [spwm_pkg::TIME_W-1:0] t);
    start          <= 1'b1;
    in_sample_time <= t;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(t);
  endtask

  // One register write; cfg_valid is left high for a following write and
  // lowered by the caller when the sequence is done.
  task automatic cfg_write(logic [spwm_pkg::CFG_IDX_W-1:0] idx,
                           logic [spwm_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  // Registers only change with the pipeline empty. Every request yields a
  // result, so an empty queue of expected duty values means the design is idle.
  task automatic wait_idle();
    while (sb.expected_duty.size() != 0) @(posedge clk);
  endtask

  // Load both registers. The amplitude word may carry junk in its upper data
  // bits, which the register must drop. Optionally a write to an index that
  // decodes to nothing follows; it must leave both registers alone.
  task automatic load_settings(logic [spwm_pkg::FREQ_W-1:0] freq_val,
                               logic [spwm_pkg::CFG_DATA_W-1:0] amp_word,
                               bit add_unused_write);
    wait_idle();
    cfg_write(spwm_pkg::CFG_IDX_FREQ, spwm_pkg::CFG_DATA_W'(freq_val));
    cfg_write(spwm_pkg::CFG_IDX_AMP, amp_word);
    if (add_unused_write) begin
      cfg_write(spwm_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_UNUSED_LO, CFG_IDX_UNUSED_HI)),
                spwm_pkg::CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [spwm_pkg::FREQ_W-1:0] pick_freq();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return FREQ_MAX;
      2: return spwm_pkg::FREQ_RESET;
      // Powers of two put the landmark times below on exact quarter turns.
      3, 4: return spwm_pkg::FREQ_W'(1) << $urandom_range(0, spwm_pkg::FREQ_W - 1);
      default: return spwm_pkg::FREQ_W'($urandom_range(0, FREQ_MAX));
    endcase
  endfunction

  function automatic logic [spwm_pkg::AMP_W-1:0] pick_amp();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return AMP_MAX;
      2: return AMP_UNITY;
      // Just around unity, where clamping and rounding meet.
      3: return spwm_pkg::AMP_W'($urandom_range(16000, 16800));
      default: return spwm_pkg::AMP_W'($urandom_range(0, AMP_MAX));
    endcase
  endfunction

  function automatic logic [spwm_pkg::TIME_W-1:0] pick_sample_time();
    case ($urandom_range(0, 9))
      0: return spwm_pkg::TIME_W'($urandom_range(0, 4095));
      1: return 32'hFFFF_FFFF - spwm_pkg::TIME_W'($urandom_range(0, 4095));
      // Close to a multiple of a quarter turn for power-of-two frequencies.
      2, 3: return (32'($urandom_range(0, 63)) << 26) + 32'($urandom_range(0, 64)) - 32'd32;
      default: return spwm_pkg::TIME_W'($urandom);
    endcase
  endfunction

  // Random traffic in bursts. Most bursts are short with short gaps so that
  // gaps land on every pipeline stage; now and then a long burst runs with
  // no gap at all at full rate.
  task automatic drive_random_requests(int unsigned count);
    int unsigned sent, burst_len, gap_len;
    sent = 0;
    while (sent < count) begin
      burst_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      for (int unsigned i = 0; i < burst_len && sent < count; i++) begin
        send_request(pick_sample_time());
        sent++;
      end
      if (sent < count) begin
        gap_len = $urandom_range(1, 15);
        start <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    start <= 1'b0;
  endtask

  task automatic drive_directed(logic [spwm_pkg::TIME_W-1:0] times[$]);
    foreach (times[i]) begin
      send_request(times[i]);
    end
    start <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values of both registers: 50 Hz at an amplitude of about 0.8.
    drive_directed('{32'd0, 32'd1, 32'hFFFF_FFFF});

    // One count of frequency at unity amplitude: the sample time maps straight
    // onto the phase, so each landmark of the fold can be hit exactly. At the
    // quarter turn the polynomial overshoots 1.0 and the output clamps high;
    // at three quarters the normalized value goes negative and the output
    // clamps to zero; at exactly one half the folded angle is zero.
    load_settings(18'd1, spwm_pkg::CFG_DATA_W'(AMP_UNITY), 1'b0);
    drive_directed('{32'd0, QUARTER_T - 32'd16, QUARTER_T, QUARTER_T + 32'd16,
                     2 * QUARTER_T - 32'd16, 2 * QUARTER_T, 2 * QUARTER_T + 32'd16,
                     3 * QUARTER_T, 3 * QUARTER_T + 32'd16, 32'hFFFF_FFFF});

    // Largest frequency and an all-ones amplitude word: the masked amplitude
    // is above 1.0. Writes to undecoded indexes follow and must be ignored.
    wait_idle();
    cfg_write(spwm_pkg::CFG_IDX_FREQ, spwm_pkg::CFG_DATA_W'(FREQ_MAX));
    cfg_write(spwm_pkg::CFG_IDX_AMP, '1);
    cfg_write(CFG_IDX_UNUSED_LO, 18'h15555);
    cfg_write(CFG_IDX_UNUSED_HI, 18'h2AAAA);
    cfg_valid <= 1'b0;
    drive_directed('{32'd1, 32'h8000_0000, 32'hFFFF_FFFF});

    // Both registers at zero: every duty value must be zero.
    load_settings('0, '0, 1'b0);
    drive_directed('{32'hFFFF_FFFF, 32'h1234_5678});

    // Random phases, each with its own register settings.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_settings(pick_freq(),
                    {spwm_pkg::CFG_DATA_W'($urandom_range(0, 7)) << spwm_pkg::AMP_W} |
                      spwm_pkg::CFG_DATA_W'(pick_amp()),
                    $urandom_range(0, 2) == 0);
      drive_random_requests(PHASE_REQUESTS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.fail_count += sb.expected_duty.size();
    if (sb.fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
